>>> hdl/local_binary_pattern_3x3_top_defines.svh
// Assertion macros for the 3x3 local binary pattern block.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef LOCAL_BINARY_PATTERN_3X3_TOP_DEFINES_SVH
`define LOCAL_BINARY_PATTERN_3X3_TOP_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define LBP3_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lbp3 same-cycle check failed");

// Next-cycle implication, disabled while in reset
`define LBP3_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lbp3 next-cycle check failed");

`endif

>>> hdl/lbp3_pkg.sv
// Shared types and constants of the 3x3 local binary pattern block.
// No dependencies; imported by every module of the block but lbp3_ram.
package lbp3_pkg;

  localparam int LBP3_MAX_WIDTH  = 1024;
  localparam int LBP3_MAX_HEIGHT = 4096;
  localparam int QUEUE_DEPTH     = 4;

  localparam int PIX_W      = 8;
  localparam int ROW_W      = 12;
  localparam int COL_OUT_W  = 10;
  localparam int WIDTH_W    = 11;
  localparam int HEIGHT_W   = 13;
  localparam int CFG_W      = 13;
  localparam int CFG_IDX_W  = 2;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1
  } lbp3_reg_e;

  // One result item
  typedef struct packed {
    logic [PIX_W-1:0]     code;
    logic [ROW_W-1:0]     row;
    logic [COL_OUT_W-1:0] col;
    logic                 last;
  } lbp3_res_t;

  // Front to queue: push strobe with its item
  typedef struct packed {
    logic      valid;
    lbp3_res_t res;
  } lbp3_push_t;

endpackage

>>> hdl/lbp3_ram.sv
// Generic single-write, single-read RAM with registered read data (read-first).
// No dependencies.
module lbp3_ram #(
  parameter int Width = 8,
  parameter int Depth = 1024,
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/lbp3_front.sv
// Front end: accepts pixels, tracks frame position, keeps line stores and window,
// and forms codes. Depends on lbp3_pkg and lbp3_ram.
module lbp3_front
  import lbp3_pkg::*;
#(
  parameter int MaxWidth = LBP3_MAX_WIDTH,
  localparam int CW = (MaxWidth > 1) ? $clog2(MaxWidth) : 1,
  localparam int QCW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 pixel_valid_i,
  input  logic [PIX_W-1:0]     pixel_i,
  output logic                 pixel_stall_o,
  input  logic [QCW-1:0]       q_count_i,
  output lbp3_push_t           push_o
);

  logic [WIDTH_W-1:0]  width_q;
  logic [HEIGHT_W-1:0] height_q;
  logic                cfg_hit;
  logic [CW-1:0]       last_col;
  logic [ROW_W-1:0]    last_row;
  logic [CW-1:0]       col_q;
  logic [ROW_W-1:0]    row_q;
  logic                accept;

  logic                s1_valid_q;
  logic [PIX_W-1:0]    s1_pix_q;
  logic [CW-1:0]       s1_col_q;
  logic [ROW_W-1:0]    s1_row_q;
  logic                s1_emit_q;
  logic                s1_last_q;

  logic [PIX_W-1:0]    top_rd;
  logic [PIX_W-1:0]    mid_rd;
  logic [PIX_W-1:0]    win_q [6];
  logic [PIX_W-1:0]    ctr;
  logic [PIX_W-1:0]    code;

  // Hold off while the queue could not take every item in flight
  assign pixel_stall_o = ((QCW+1)'(q_count_i) + (QCW+1)'(s1_valid_q))
                         >= (QCW+1)'(QUEUE_DEPTH);
  assign accept = pixel_valid_i && !pixel_stall_o;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_IMAGE_WIDTH:  width_q  <= cfg_data_i[WIDTH_W-1:0];
        REG_IMAGE_HEIGHT: height_q <= cfg_data_i[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_hit = cfg_we_i && ((cfg_idx_i == REG_IMAGE_WIDTH) ||
                                (cfg_idx_i == REG_IMAGE_HEIGHT));

  // Clamp frame size to its legal range, expressed as last column and row
  always_comb begin
    if (width_q < WIDTH_W'(3)) begin
      last_col = CW'(2);
    end else if (32'(width_q) > MaxWidth) begin
      last_col = CW'(MaxWidth - 1);
    end else begin
      last_col = CW'(width_q - WIDTH_W'(1));
    end
    if (height_q < HEIGHT_W'(3)) begin
      last_row = ROW_W'(2);
    end else if (32'(height_q) > LBP3_MAX_HEIGHT) begin
      last_row = ROW_W'(LBP3_MAX_HEIGHT - 1);
    end else begin
      last_row = ROW_W'(height_q - HEIGHT_W'(1));
    end
  end

  // Position of the next pixel; restart on a write to either configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cfg_hit) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      if (col_q == last_col) begin
        col_q <= '0;
        row_q <= (row_q == last_row) ? '0 : row_q + ROW_W'(1);
      end else begin
        col_q <= col_q + CW'(1);
      end
    end
  end

  // Stage one: line store read in flight
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q  <= pixel_i;
      s1_col_q  <= col_q;
      s1_row_q  <= row_q;
      s1_emit_q <= (row_q >= ROW_W'(2)) && (col_q >= CW'(2));
      s1_last_q <= (row_q == last_row) && (col_q == last_col);
    end
  end

  // Line stores: read at acceptance, shift down one row in the next cycle
  lbp3_ram #(
    .Width (PIX_W),
    .Depth (MaxWidth)
  ) u_upper_ram (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_col_q),
    .wdata_i (mid_rd),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (top_rd)
  );

  lbp3_ram #(
    .Width (PIX_W),
    .Depth (MaxWidth)
  ) u_middle_ram (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_col_q),
    .wdata_i (s1_pix_q),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (mid_rd)
  );

  // Window: two columns left of the incoming one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else if (s1_valid_q) begin
      win_q[0] <= win_q[3];
      win_q[1] <= win_q[4];
      win_q[2] <= win_q[5];
      win_q[3] <= top_rd;
      win_q[4] <= mid_rd;
      win_q[5] <= s1_pix_q;
    end
  end

  // Compare the eight neighbors against the center
  assign ctr = win_q[4];
  always_comb begin
    code[7] = win_q[0] > ctr;
    code[6] = win_q[3] > ctr;
    code[5] = top_rd   > ctr;
    code[4] = mid_rd   > ctr;
    code[3] = s1_pix_q > ctr;
    code[2] = win_q[5] > ctr;
    code[1] = win_q[2] > ctr;
    code[0] = win_q[1] > ctr;
  end

  assign push_o.valid    = s1_valid_q && s1_emit_q;
  assign push_o.res.code = code;
  assign push_o.res.row  = s1_row_q - ROW_W'(1);
  assign push_o.res.col  = COL_OUT_W'(s1_col_q - CW'(1));
  assign push_o.res.last = s1_last_q;

endmodule

>>> hdl/lbp3_fifo.sv
// Short queue of result items between the front end and the output stage.
// Depends on lbp3_pkg.
module lbp3_fifo
  import lbp3_pkg::*;
#(
  localparam int PW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
  localparam int QCW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  lbp3_push_t     push_i,
  input  logic           pop_i,
  output lbp3_res_t      head_o,
  output logic           nonempty_o,
  output logic [QCW-1:0] count_o
);

  lbp3_res_t      mem_q [QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr_q;
  logic [PW-1:0]  rd_ptr_q;
  logic [QCW-1:0] count_q;

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem_q[wr_ptr_q] <= push_i.res;
    end
  end

  // Pointers and fill count; hold the count when push and pop coincide
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i.valid) begin
        wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      if (push_i.valid && !pop_i) begin
        count_q <= count_q + QCW'(1);
      end else if (pop_i && !push_i.valid) begin
        count_q <= count_q - QCW'(1);
      end
    end
  end

  assign head_o     = mem_q[rd_ptr_q];
  assign nonempty_o = (count_q != '0);
  assign count_o    = count_q;

endmodule

>>> hdl/lbp3_back.sv
// Output stage: takes items from the queue and holds them for the receiver.
// Depends on lbp3_pkg.
module lbp3_back
  import lbp3_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lbp3_res_t            head_i,
  input  logic                 nonempty_i,
  output logic                 pop_o,
  output logic                 lbp_valid_o,
  input  logic                 lbp_stall_i,
  output logic [PIX_W-1:0]     lbp_code_o,
  output logic [ROW_W-1:0]     center_row_o,
  output logic [COL_OUT_W-1:0] center_col_o,
  output logic                 frame_last_o
);

  logic      out_valid_q;
  lbp3_res_t out_q;

  // Load when the register is empty or being drained
  assign pop_o = nonempty_i && (!out_valid_q || !lbp_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (!lbp_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= head_i;
    end
  end

  assign lbp_valid_o  = out_valid_q;
  assign lbp_code_o   = out_q.code;
  assign center_row_o = out_q.row;
  assign center_col_o = out_q.col;
  assign frame_last_o = out_q.last;

endmodule

>>> hdl/local_binary_pattern_3x3_top.sv
// 3x3 local binary pattern over a streamed grey frame.
// Pixels enter on the pixel channel (pixel_valid_i / pixel_stall_o / pixel_i) in
// raster order; frame position is tracked inside the block.
// Codes leave on the lbp channel (lbp_valid_o / lbp_stall_i) with the center's
// row and column and a frame_last flag on the last interior code of a frame.
// Border pixels produce no code; the consumer fills them.
// Throughput: one pixel per clock, sustained, while the receiver takes codes.
// Path: the pixel completing a window is registered in the line store read stage,
// and its code then passes through the queue into the output register.
// Receiver stall: codes collect in a four-entry queue behind the output register;
// pixel_stall_o rises once the queue cannot absorb the items in flight.
// Configuration: write image_width (index 0) or image_height (index 1) only while
// idle; a write to either register restarts the frame at row zero, column zero.
// Reset: position counters and window clear, frame size goes to 640 x 480; line
// stores keep no reset value and need no clearing pass.
// Depends on lbp3_pkg, lbp3_front, lbp3_fifo, lbp3_back and the macro header.
`include "local_binary_pattern_3x3_top_defines.svh"

module local_binary_pattern_3x3_top
  import lbp3_pkg::*;
#(
  parameter int MAX_WIDTH = LBP3_MAX_WIDTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 pixel_valid_i,
  output logic                 pixel_stall_o,
  input  logic [PIX_W-1:0]     pixel_i,
  output logic                 lbp_valid_o,
  input  logic                 lbp_stall_i,
  output logic [PIX_W-1:0]     lbp_code_o,
  output logic [ROW_W-1:0]     center_row_o,
  output logic [COL_OUT_W-1:0] center_col_o,
  output logic                 frame_last_o
);

  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  lbp3_push_t     push;
  lbp3_res_t      q_head;
  logic           q_nonempty;
  logic           q_pop;
  logic [QCW-1:0] q_count;

  // Accept, position, line stores, window and code
  lbp3_front #(
    .MaxWidth (MAX_WIDTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .pixel_valid_i (pixel_valid_i),
    .pixel_i       (pixel_i),
    .pixel_stall_o (pixel_stall_o),
    .q_count_i     (q_count),
    .push_o        (push)
  );

  // Decoupling queue
  lbp3_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .pop_i      (q_pop),
    .head_o     (q_head),
    .nonempty_o (q_nonempty),
    .count_o    (q_count)
  );

  // Output register
  lbp3_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (q_head),
    .nonempty_i   (q_nonempty),
    .pop_o        (q_pop),
    .lbp_valid_o  (lbp_valid_o),
    .lbp_stall_i  (lbp_stall_i),
    .lbp_code_o   (lbp_code_o),
    .center_row_o (center_row_o),
    .center_col_o (center_col_o),
    .frame_last_o (frame_last_o)
  );

  // Credit check: a push never lands in a full queue
  `LBP3_ASSERT_IMP(a_queue_no_overflow, push.valid, (q_count < QCW'(QUEUE_DEPTH)) || q_pop)
  // Codes belong to interior rows only
  `LBP3_ASSERT_IMP(a_row_interior, lbp_valid_o, center_row_o != '0)
  // An item taken from the queue shows on the output next cycle
  `LBP3_ASSERT_NXT(a_pop_shows, q_pop, lbp_valid_o)

endmodule
